FILE: rtl/core/c3x3_pkg.sv
// Shared constants, types and register codes of the 3x3 convolution filter.
// Used by every module of the filter core; depends on nothing.
package c3x3_pkg;

  // Frame geometry and coefficient format
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int CoefBits  = 8;

  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int SizeW = 11;
  localparam int PixW  = 8;
  localparam int Taps  = 9;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int CoefRegW = 3 * CoefBits;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 3'd0,
    RegImageHeight = 3'd1,
    RegCoefLeft    = 3'd2,
    RegCoefMid     = 3'd3,
    RegCoefRight   = 3'd4
  } cfg_reg_e;

  // Arithmetic widths: product, nine-term sum, magnitude of the sum
  localparam int ProdW = CoefBits + PixW + 1;
  localparam int SumW  = ProdW + 4;
  localparam int AbsW  = SumW - 1;

  // Divide by nine as multiply by ceil(2^k / 9); exact for magnitudes below 2^AbsW
  localparam int RecipShift = AbsW + 3;
  localparam logic [AbsW-1:0] RecipNine =
    AbsW'(((longint'(1) << RecipShift) + longint'(8)) / longint'(9));

  // Output stream packing
  localparam int OutBits  = ColW + RowW + PixW;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

  typedef logic [Taps-1:0][PixW-1:0]     pix_arr_t;
  typedef logic [Taps-1:0][CoefBits-1:0] coef_arr_t;

  // Sideband that travels with a result through the arithmetic stages
  typedef struct packed {
    logic [ColW-1:0] out_x;
    logic [RowW-1:0] out_y;
    logic            frame_done;
  } side_t;

endpackage

FILE: rtl/core/conv3x3_image_filter_core.sv
// Top level of the 3x3 convolution filter: configuration, position counters,
// window registers, output register. Depends on c3x3_pkg, c3x3_line_buf, c3x3_mac.
//
// Usage:
//   Pixels enter on the s_axis channel in raster order, one per item; tuser
//   flags the first pixel of a frame and resets the position counters. The
//   counters also wrap on their own after the last pixel of a frame.
//   For every pixel that completes an interior 3x3 window the m_axis channel
//   gives one item with the window's center position and the weighted sum
//   divided by nine (toward zero, low 8 bits kept); tlast marks the last
//   interior pixel of the frame. Border pixels give no item.
//   Registers (width, height, three coefficient columns) are written on the
//   cfg channel, which is always ready; write them only while the filter is
//   idle.
//   Throughput is one pixel per clock while the receiver keeps up. A result
//   is valid once its pixel has passed these steps in order: the line buffer
//   read at the accepting edge, then the products, the sum and the divide,
//   each registered, the last one ending in the output register.
//   When the receiver stalls, the whole pipeline holds and tready drops only
//   while a result is waiting in the output register.
//   Reset clears counters, window and pipeline valids and restores register
//   defaults (320 x 240, zero coefficients). Line buffer contents are left
//   as they are and are rewritten by the first two rows of a frame.
module conv3x3_image_filter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel
  input  logic                              s_axis_tuser,   // [0] frame_start
  // Result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [c3x3_pkg::OutDataW-1:0]     m_axis_tdata,   // out_x, out_y, filtered, zero pad
  output logic                              m_axis_tlast,   // frame_done
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [c3x3_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [c3x3_pkg::CfgDataW-1:0]     cfg_data_i
);
  import c3x3_pkg::*;

  // Configuration registers
  logic [SizeW-1:0]    width_q;
  logic [SizeW-1:0]    height_q;
  logic [CoefRegW-1:0] coef_q [3];

  // Position counters
  logic [ColW-1:0]     col_q;
  logic [RowW-1:0]     row_q;

  // Input stage
  logic                s1_valid_q;
  logic [ColW-1:0]     s1_x_q;
  logic [RowW-1:0]     s1_y_q;
  logic [PixW-1:0]     s1_pix_q;
  logic                s1_int_q;
  logic                s1_done_q;
  logic                byp_q;
  logic [PixW-1:0]     byp_top_q;
  logic [PixW-1:0]     byp_mid_q;

  // Window of the two previous columns
  logic [PixW-1:0]     win_q [6];

  // Output register
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_last_q;

  logic                en;
  logic                acc;
  logic                adv1;
  logic [SizeW-1:0]    w_eff;
  logic [SizeW-1:0]    h_eff;
  logic [SizeW-1:0]    col0;
  logic [SizeW-1:0]    row0;
  logic [SizeW-1:0]    row_t;
  logic [SizeW-1:0]    x_w;
  logic [SizeW-1:0]    y_w;
  logic [SizeW-1:0]    nx;
  logic [SizeW-1:0]    ny;
  logic [ColW-1:0]     x;
  logic [RowW-1:0]     y;
  logic [ColW-1:0]     col_d;
  logic [RowW-1:0]     row_d;
  logic                interior;
  logic                last_pos;

  logic [PixW-1:0]     rd_older;
  logic [PixW-1:0]     rd_newer;
  logic [PixW-1:0]     s1_top;
  logic [PixW-1:0]     s1_mid;

  pix_arr_t            pix;
  coef_arr_t           coef;
  side_t               side_in;
  side_t               side_out;
  logic                mac_valid;
  logic [PixW-1:0]     mac_filtered;

  // Handshakes: the pipeline moves whenever the output register can take an item
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign adv1          = en && s1_valid_q;
  assign cfg_ready_o   = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(320);
      height_q <= SizeW'(240);
      coef_q   <= '{default: '0};
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        RegImageWidth:  width_q   <= SizeW'(cfg_data_i);
        RegImageHeight: height_q  <= SizeW'(cfg_data_i);
        RegCoefLeft:    coef_q[0] <= CoefRegW'(cfg_data_i);
        RegCoefMid:     coef_q[1] <= CoefRegW'(cfg_data_i);
        RegCoefRight:   coef_q[2] <= CoefRegW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp sizes and place the incoming pixel
  always_comb begin
    if (width_q < SizeW'(3))              w_eff = SizeW'(3);
    else if (width_q > SizeW'(MaxWidth))  w_eff = SizeW'(MaxWidth);
    else                                  w_eff = width_q;
    if (height_q < SizeW'(3))             h_eff = SizeW'(3);
    else if (height_q > SizeW'(MaxHeight)) h_eff = SizeW'(MaxHeight);
    else                                  h_eff = height_q;

    col0 = s_axis_tuser ? '0 : SizeW'(col_q);
    row0 = s_axis_tuser ? '0 : SizeW'(row_q);
    if (col0 >= w_eff) begin
      x_w   = '0;
      row_t = row0 + 1'b1;
    end else begin
      x_w   = col0;
      row_t = row0;
    end
    y_w = (row_t >= h_eff) ? '0 : row_t;
    x   = x_w[ColW-1:0];
    y   = y_w[RowW-1:0];

    // Advance to the next position
    nx = x_w + 1'b1;
    ny = y_w + 1'b1;
    if (nx >= w_eff) begin
      col_d = '0;
      row_d = (ny >= h_eff) ? '0 : ny[RowW-1:0];
    end else begin
      col_d = nx[ColW-1:0];
      row_d = y;
    end

    interior = (x_w >= SizeW'(2)) && (y_w >= SizeW'(2));
    last_pos = (x_w == w_eff - 1'b1) && (y_w == h_eff - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line buffers
  c3x3_line_buf u_line_buf (
    .clk_i      (clk_i),
    .rd_en_i    (acc),
    .rd_addr_i  (x),
    .rd_older_o (rd_older),
    .rd_newer_o (rd_newer),
    .wr_en_i    (adv1),
    .wr_addr_i  (s1_x_q),
    .wr_older_i (s1_mid),
    .wr_newer_i (s1_pix_q)
  );

  // Forward the column written in the same cycle as it was read
  assign s1_top = byp_q ? byp_top_q : rd_older;
  assign s1_mid = byp_q ? byp_mid_q : rd_newer;

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
      byp_q      <= acc && s1_valid_q && (s1_x_q == x);
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_x_q    <= x;
      s1_y_q    <= y;
      s1_pix_q  <= s_axis_tdata;
      s1_int_q  <= interior;
      s1_done_q <= last_pos;
      byp_top_q <= s1_mid;
      byp_mid_q <= s1_pix_q;
    end
  end

  // Shift the window by one column when the item leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '{default: '0};
    end else if (adv1) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= s1_top;
      win_q[4] <= s1_mid;
      win_q[5] <= s1_pix_q;
    end
  end

  // Gather window taps and coefficients, column offset major
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pix[i] = win_q[i];
    end
    pix[6] = s1_top;
    pix[7] = s1_mid;
    pix[8] = s1_pix_q;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        coef[a*3+b] = coef_q[a][b*CoefBits +: CoefBits];
      end
    end
  end

  assign side_in.out_x      = s1_x_q - 1'b1;
  assign side_in.out_y      = s1_y_q - 1'b1;
  assign side_in.frame_done = s1_done_q;

  c3x3_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s1_valid_q && s1_int_q),
    .side_i     (side_in),
    .pix_i      (pix),
    .coef_i     (coef),
    .valid_o    (mac_valid),
    .side_o     (side_out),
    .filtered_o (mac_filtered)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= mac_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= OutDataW'({mac_filtered, side_out.out_y, side_out.out_x});
      m_last_q <= side_out.frame_done;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // A result always sits inside the frame border
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[ColW-1:0] != '0) &&
                      (m_axis_tdata[ColW +: RowW] != '0))
    else $error("result on a border position");

  // Forwarding only when the same column is read back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> s1_valid_q && (s1_x_q == $past(s1_x_q)))
    else $error("line buffer forwarding without a repeated column");

  // The window shifts exactly when an item leaves the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv1 |=> (win_q[0] == $past(win_q[3])) && (win_q[5] == $past(s1_pix_q)))
    else $error("window did not shift");

endmodule

FILE: rtl/core/c3x3_line_buf.sv
// Two line buffers of the filter: the row two above and the row above.
// One write and one registered read per cycle each; depends on c3x3_pkg.
module c3x3_line_buf (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [c3x3_pkg::ColW-1:0]   rd_addr_i,
  output logic [c3x3_pkg::PixW-1:0]   rd_older_o,
  output logic [c3x3_pkg::PixW-1:0]   rd_newer_o,
  input  logic                        wr_en_i,
  input  logic [c3x3_pkg::ColW-1:0]   wr_addr_i,
  input  logic [c3x3_pkg::PixW-1:0]   wr_older_i,
  input  logic [c3x3_pkg::PixW-1:0]   wr_newer_i
);
  import c3x3_pkg::*;

  logic [PixW-1:0] older_mem [MaxWidth];
  logic [PixW-1:0] newer_mem [MaxWidth];
  logic [PixW-1:0] rd_older_q;
  logic [PixW-1:0] rd_newer_q;

  // Shift the column down one line
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= wr_older_i;
      newer_mem[wr_addr_i] <= wr_newer_i;
    end
  end

  // Fetch the column above the incoming pixel
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_older_q <= older_mem[rd_addr_i];
      rd_newer_q <= newer_mem[rd_addr_i];
    end
  end

  assign rd_older_o = rd_older_q;
  assign rd_newer_o = rd_newer_q;

endmodule

FILE: rtl/core/c3x3_mac.sv
// Weighted sum of a 3x3 window and division by nine toward zero.
// Two register stages (products, then signed magnitude); depends on c3x3_pkg.
module c3x3_mac (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  c3x3_pkg::side_t               side_i,
  input  c3x3_pkg::pix_arr_t            pix_i,
  input  c3x3_pkg::coef_arr_t           coef_i,
  output logic                          valid_o,
  output c3x3_pkg::side_t               side_o,
  output logic [c3x3_pkg::PixW-1:0]     filtered_o
);
  import c3x3_pkg::*;

  logic signed [ProdW-1:0] prod_d [Taps];
  logic signed [ProdW-1:0] prod_q [Taps];
  logic                    valid2_q;
  side_t                   side2_q;

  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  mag;
  logic [AbsW-1:0]         abs_d;
  logic [AbsW-1:0]         abs_q;
  logic                    neg_q;
  logic                    valid3_q;
  side_t                   side3_q;

  logic [2*AbsW-1:0]       scaled;
  logic [PixW-1:0]         quo_lo;

  // Nine coefficient-times-pixel products
  always_comb begin
    for (int i = 0; i < Taps; i++) begin
      prod_d[i] = ProdW'($signed({1'b0, pix_i[i]})) * ProdW'($signed(coef_i[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      side2_q <= side_i;
    end
  end

  // Add the products and split into sign and magnitude
  always_comb begin
    sum = '0;
    for (int i = 0; i < Taps; i++) begin
      sum = sum + SumW'(prod_q[i]);
    end
    mag   = sum[SumW-1] ? -sum : sum;
    abs_d = mag[AbsW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q   <= abs_d;
      neg_q   <= sum[SumW-1];
      side3_q <= side2_q;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid_i;
      valid3_q <= valid2_q;
    end
  end

  // Divide the magnitude by nine and restore the sign on the low bits
  assign scaled     = abs_q * RecipNine;
  assign quo_lo     = scaled[RecipShift +: PixW];
  assign filtered_o = neg_q ? (~quo_lo + 1'b1) : quo_lo;
  assign valid_o    = valid3_q;
  assign side_o     = side3_q;

endmodule

FILE: verif/conv3x3_image_filter_core_test.sv
// Self-checking test of the 3x3 convolution filter core: random pixel frames,
// stalls on both streams, register changes between runs, predicted results.
// Depends on c3x3_pkg and conv3x3_image_filter_core.
module conv3x3_image_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import c3x3_pkg::*;

  localparam int          PipeDrain = 8;
  localparam int unsigned TimeoutNs = 60_000_000;
  localparam int          SrcSide   = 0;
  localparam int          SinkSide  = 1;
  localparam logic [4:0]  AllRegs   = 5'b11111;
  localparam logic [4:0]  CoefRegs  = 5'b11100;

  typedef struct packed {
    logic [ColW-1:0] out_x;
    logic [RowW-1:0] out_y;
    logic [PixW-1:0] filtered;
    logic            frame_done;
  } filtered_item_t;

  // Track register and window state; queue the expected filtered pixels
  class filter_scoreboard;
    logic [SizeW-1:0]    width_reg;
    logic [SizeW-1:0]    height_reg;
    logic [CoefRegW-1:0] coef_reg [3];
    logic [PixW-1:0]     older_row [MaxWidth];
    logic [PixW-1:0]     newer_row [MaxWidth];
    logic [PixW-1:0]     window [6];
    int unsigned         col;
    int unsigned         row;
    filtered_item_t      due_filtered [$];
    int                  mismatches;

    function new();
      width_reg  = 320;
      height_reg = 240;
      foreach (coef_reg[i]) coef_reg[i] = '0;
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      foreach (window[i]) window[i] = '0;
      col        = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned used_width();
      return clamp_dim(width_reg, MaxWidth);
    endfunction

    function int unsigned used_height();
      return clamp_dim(height_reg, MaxHeight);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegImageWidth:  width_reg = data[SizeW-1:0];
        RegImageHeight: height_reg = data[SizeW-1:0];
        RegCoefLeft:    coef_reg[0] = data[CoefRegW-1:0];
        RegCoefMid:     coef_reg[1] = data[CoefRegW-1:0];
        RegCoefRight:   coef_reg[2] = data[CoefRegW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the position, update line rows and window, filter interior pixels
    function void accept_pixel(logic [PixW-1:0] pix, logic fs);
      int unsigned    w, h, x, y;
      logic [PixW-1:0] top, mid;
      logic [PixW-1:0] taps [3][3];
      int             acc, c;
      filtered_item_t r;
      w = used_width();
      h = used_height();
      if (fs) begin
        col = 0;
        row = 0;
      end
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      x = col;
      y = row;

      top = older_row[x];
      mid = newer_row[x];
      older_row[x] = mid;
      newer_row[x] = pix;

      if (x >= 2 && y >= 2) begin
        for (int b = 0; b < 3; b++) begin
          taps[0][b] = window[b];
          taps[1][b] = window[3+b];
        end
        taps[2] = '{top, mid, pix};
        acc = 0;
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            c = $signed(coef_reg[a][CoefBits*b +: CoefBits]);
            acc += c * int'(taps[a][b]);
          end
        end
        acc = acc / Taps;
        r.out_x      = ColW'(x - 1);
        r.out_y      = RowW'(y - 1);
        r.filtered   = acc[PixW-1:0];
        r.frame_done = (x == w - 1) && (y == h - 1);
        due_filtered.push_back(r);
      end

      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = pix;

      col = x + 1;
      if (col >= w) begin
        col = 0;
        row = y + 1;
        if (row >= h) row = 0;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_filtered(logic [OutDataW-1:0] data, logic last);
      filtered_item_t want;
      if (due_filtered.size() == 0) begin
        $error("unexpected result item: out_x=%0d out_y=%0d filtered=%0d",
               data[ColW-1:0], data[ColW +: RowW], data[ColW+RowW +: PixW]);
        mismatches++;
        return;
      end
      want = due_filtered.pop_front();
      compare_field("out_x", want.out_x, data[ColW-1:0]);
      compare_field("out_y", want.out_y, data[ColW +: RowW]);
      compare_field("filtered", want.filtered, data[ColW+RowW +: PixW]);
      compare_field("frame_done", want.frame_done, last);
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  filter_scoreboard sb = new();

  int idle_left [2];
  bit idle_on [2];

  conv3x3_image_filter_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Draw the wait before the next item; alternate busy and calm stretches
  function automatic int draw_wait(int side);
    if (idle_left[side] == 0) begin
      idle_left[side] = $urandom_range(8, 60);
      idle_on[side]   = ($urandom_range(0, 3) != 0);
    end
    idle_left[side]--;
    return idle_on[side] ? int'($urandom_range(0, 18)) : 0;
  endfunction

  task automatic send_pixel(logic [7:0] pix, logic fs);
    int gap;
    gap = draw_wait(SrcSide);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.accept_pixel(pix, fs);
  endtask

  // Send random pixels; stray frame starts appear at the given percentage
  task automatic send_run(int count, bit first_fs, int noise_pct);
    for (int i = 0; i < count; i++) begin
      send_pixel(8'($urandom),
                 (i == 0) ? first_fs : ($urandom_range(0, 99) < noise_pct));
    end
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Drain the filter, then write the selected registers and, if asked, one stray unused address
  task automatic configure(logic [4:0] mask, logic [4:0][CfgDataW-1:0] vals, bit stray);
    s_axis_tvalid <= 1'b0;
    while (sb.due_filtered.size() != 0) @(posedge clk_i);
    repeat (PipeDrain) @(posedge clk_i);
    for (int r = 0; r <= int'(RegCoefRight); r++) begin
      if (mask[r]) cfg_write(CfgIdxW'(r), vals[r]);
    end
    if (stray) begin
      cfg_write(CfgIdxW'(RegCoefRight) + CfgIdxW'($urandom_range(1, 3)), CfgDataW'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(SinkSide);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_filtered(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin : stimulus
    logic [4:0][CfgDataW-1:0] vals;
    logic [4:0]               mask;
    logic [SizeW-1:0]         wv, hv;
    int unsigned              old_w;
    int                       n, rand_sent;
    bit                       fs;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, most negative coefficients, brightest pixels
    vals[RegImageWidth]  = {13'($urandom), 11'd3};
    vals[RegImageHeight] = {13'($urandom), 11'd3};
    vals[RegCoefLeft]    = 24'h808080;
    vals[RegCoefMid]     = 24'h808080;
    vals[RegCoefRight]   = 24'h808080;
    configure(AllRegs, vals, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);

    // Most positive coefficients; the next frame follows without a frame start
    vals[RegCoefLeft]  = 24'h7F7F7F;
    vals[RegCoefMid]   = 24'h7F7F7F;
    vals[RegCoefRight] = 24'h7F7F7F;
    configure(CoefRegs, vals, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 1'b0);

    // Stop inside row 1 of a 4-wide frame, then shrink the width below range
    vals[RegImageWidth]  = {13'($urandom), 11'd4};
    vals[RegImageHeight] = {13'($urandom), 11'd4};
    vals[RegCoefLeft]    = 24'($urandom);
    vals[RegCoefMid]     = 24'($urandom);
    vals[RegCoefRight]   = 24'($urandom);
    configure(AllRegs, vals, 1'b0);
    for (int i = 0; i < 7; i++) send_pixel(i[0] ? 8'hFF : 8'h00, i == 0);
    vals[RegImageWidth] = {13'($urandom), 11'd2};
    configure(5'(1) << RegImageWidth, vals, 1'b0);
    send_run(6, 1'b0, 0);

    // Widest row, clamped from the top of the register range
    vals[RegImageWidth]  = {13'($urandom), 11'h7FF};
    vals[RegImageHeight] = {13'($urandom), 11'd3};
    vals[RegCoefLeft]    = 24'($urandom);
    vals[RegCoefMid]     = 24'($urandom);
    vals[RegCoefRight]   = 24'($urandom);
    configure(AllRegs, vals, 1'b0);
    send_run(sb.used_width() * sb.used_height(), 1'b1, 0);

    // Tallest frame, narrowest clamped width
    vals[RegImageWidth]  = {13'($urandom), 11'd0};
    vals[RegImageHeight] = {13'($urandom), 11'($urandom_range(1025, 2047))};
    configure(AllRegs, vals, 1'b0);
    send_run(sb.used_width() * sb.used_height(), 1'($urandom_range(0, 1)), 0);

    // Random small frames, random coefficients, occasional truncation and noise
    rand_sent = 0;
    while (rand_sent < 600) begin
      case ($urandom_range(0, 9))
        0:       wv = 11'($urandom_range(0, 2));
        1:       wv = 11'($urandom_range(13, 40));
        default: wv = 11'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       hv = 11'($urandom_range(0, 2));
        1:       hv = 11'($urandom_range(9, 20));
        default: hv = 11'($urandom_range(3, 8));
      endcase
      vals[RegImageWidth]  = {13'($urandom), wv};
      vals[RegImageHeight] = {13'($urandom), hv};
      vals[RegCoefLeft]    = 24'($urandom);
      vals[RegCoefMid]     = 24'($urandom);
      vals[RegCoefRight]   = 24'($urandom);
      mask  = 5'($urandom);
      old_w = sb.used_width();
      configure(mask, vals, $urandom_range(0, 7) == 0);
      // A wider row needs a fresh frame so line rows are rewritten first
      fs = (sb.used_width() > old_w) ? 1'b1 : 1'($urandom_range(0, 1));
      n  = $urandom_range(1, 3) * sb.used_width() * sb.used_height();
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      send_run(n, fs, 3);
      rand_sent += n;
    end

    // Let the last results drain
    s_axis_tvalid <= 1'b0;
    while (sb.due_filtered.size() != 0) @(posedge clk_i);
    repeat (2 * PipeDrain) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/c3x3_pkg.sv
rtl/core/c3x3_line_buf.sv
rtl/core/c3x3_mac.sv
rtl/core/conv3x3_image_filter_core.sv
verif/conv3x3_image_filter_core_test.sv
